### rtl/core/button_press_classifier_unit_assert.svh
// Assertion macros for the button press classifier
// Used by bpc_core and bpc_outbuf; empty when SYNTHESIS is defined
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define BPC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define BPC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define BPC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define BPC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

### rtl/core/bpc_pkg.sv
// Shared types and constants of the button press classifier
// No dependencies
`timescale 1ns / 1ps

package bpc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_DEBOUNCE       = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS     = 3'd1;
  localparam logic [2:0] CFG_DOUBLE_PRESS   = 3'd2;
  localparam logic [2:0] CFG_IDLE_LEVEL     = 3'd3;
  localparam logic [2:0] CFG_INIT_TOGGLE    = 3'd4;
  localparam logic [2:0] CFG_INIT_LONG_TGL  = 3'd5;
  localparam logic [2:0] CFG_INIT_DBL_TGL   = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int REG_TIME_W  = 16;

  // register reset values
  localparam logic [REG_TIME_W-1:0] RST_DEBOUNCE     = 16'd20;
  localparam logic [REG_TIME_W-1:0] RST_LONG_PRESS   = 16'd0;
  localparam logic [REG_TIME_W-1:0] RST_DOUBLE_PRESS = 16'd0;
  localparam logic                  RST_IDLE_LEVEL   = 1'b1;
  localparam logic                  RST_INIT_TOGGLE  = 1'b0;
  localparam logic                  RST_INIT_LONG    = 1'b0;
  localparam logic                  RST_INIT_DOUBLE  = 1'b0;

  // default module parameters
  localparam int DEF_POLL_TICKS = 25;
  localparam int DEF_TIME_BITS  = 16;

  // stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // live configuration seen by the classifier
  typedef struct packed {
    logic [REG_TIME_W-1:0] debounce_ticks;
    logic [REG_TIME_W-1:0] long_press_ticks;
    logic [REG_TIME_W-1:0] double_press_ticks;
    logic                  idle_level;
  } bpc_cfg_t;

  // one result item, first field in the highest bit
  typedef struct packed {
    logic busy_res;
    logic double_toggle_out;
    logic long_toggle_out;
    logic toggle_out;
    logic double_event;
    logic long_event;
    logic press_event;
  } bpc_result_t;

endpackage

### rtl/core/bpc_cfg.sv
// Configuration register file of the button press classifier
// Depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bpc_pkg::bpc_cfg_t                  cfg
);

  // register writes; the initial toggle registers only matter at reset,
  // where reset also returns them to their reset values, so they hold no bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= bpc_pkg::RST_DEBOUNCE;
      cfg.long_press_ticks   <= bpc_pkg::RST_LONG_PRESS;
      cfg.double_press_ticks <= bpc_pkg::RST_DOUBLE_PRESS;
      cfg.idle_level         <= bpc_pkg::RST_IDLE_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_wdata[15:0];
        bpc_pkg::CFG_LONG_PRESS:   cfg.long_press_ticks   <= cfg_wdata[15:0];
        bpc_pkg::CFG_DOUBLE_PRESS: cfg.double_press_ticks <= cfg_wdata[15:0];
        bpc_pkg::CFG_IDLE_LEVEL:   cfg.idle_level         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/bpc_core.sv
// Press classification state machine: one tick per request
// Depends on bpc_pkg and button_press_classifier_unit_assert.svh
`timescale 1ns / 1ps
`include "button_press_classifier_unit_assert.svh"

module bpc_core #(
  parameter int POLL_TICKS = bpc_pkg::DEF_POLL_TICKS,
  parameter int TIME_BITS  = bpc_pkg::DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  pin_level,
  input  bpc_pkg::bpc_cfg_t     cfg,
  output bpc_pkg::bpc_result_t  res_next
);

  localparam int POLL_W = $clog2(POLL_TICKS + 1);
  localparam int CMP_W  = (TIME_BITS > bpc_pkg::REG_TIME_W) ? TIME_BITS : bpc_pkg::REG_TIME_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [POLL_W-1:0]    POLL_LAST = POLL_W'(POLL_TICKS);
  localparam logic [TIME_BITS:0]   POLL_STEP = (TIME_BITS + 1)'(POLL_TICKS);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2,
    PH_RELEASE  = 2'd3
  } phase_t;

  phase_t               phase, phase_next;
  logic [TIME_BITS-1:0] phase_count, phase_count_next;
  logic [POLL_W-1:0]    poll_count, poll_count_next;
  logic                 prev_level;
  logic [TIME_BITS-1:0] since_press, since_press_next;
  logic                 press_valid, press_valid_next;
  logic                 toggle_bit, toggle_bit_next;
  logic                 long_toggle_bit, long_toggle_bit_next;
  logic                 double_toggle_bit, double_toggle_bit_next;

  logic                 active;
  logic [POLL_W-1:0]    poll_inc;
  logic                 poll_due;
  logic [TIME_BITS:0]   hold_sum;
  logic                 classify;
  logic                 is_double;
  logic                 long_hit;

  assign active   = (pin_level != cfg.idle_level);
  assign poll_inc = poll_count + POLL_W'(1);
  assign poll_due = (poll_inc >= POLL_LAST);
  assign hold_sum = {1'b0, phase_count} + POLL_STEP;

  // next state for one tick
  always_comb begin
    phase_next             = phase;
    phase_count_next       = phase_count;
    poll_count_next        = poll_count;
    since_press_next       = since_press;
    press_valid_next       = press_valid;
    toggle_bit_next        = toggle_bit;
    long_toggle_bit_next   = long_toggle_bit;
    double_toggle_bit_next = double_toggle_bit;
    classify               = 1'b0;
    long_hit               = 1'b0;
    is_double              = 1'b0;

    // time since the last valid press, saturating
    if (press_valid && since_press != TIME_MAX) begin
      since_press_next = since_press + TIME_BITS'(1);
    end

    // phase transitions
    unique case (phase)
      PH_IDLE: begin
        if (prev_level == cfg.idle_level && active) begin
          phase_next       = PH_DEBOUNCE;
          phase_count_next = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (phase_count != TIME_MAX) begin
          phase_count_next = phase_count + TIME_BITS'(1);
        end
      end
      PH_HOLD: begin
        poll_count_next = poll_due ? '0 : poll_inc;
        if (poll_due) begin
          phase_count_next = hold_sum[TIME_BITS] ? TIME_MAX : hold_sum[TIME_BITS-1:0];
          if (!active) begin
            classify   = 1'b1;
            phase_next = PH_IDLE;
          end else if (CMP_W'(phase_count_next) >= CMP_W'(cfg.long_press_ticks)) begin
            long_hit        = 1'b1;
            phase_next      = PH_RELEASE;
            poll_count_next = '0;
          end
        end
      end
      PH_RELEASE: begin
        poll_count_next = poll_due ? '0 : poll_inc;
        if (poll_due && !active) begin
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase

    // debounce sample, also in the edge tick when the wait is zero
    if (phase_next == PH_DEBOUNCE &&
        CMP_W'(phase_count_next) >= CMP_W'(cfg.debounce_ticks)) begin
      if (!active) begin
        phase_next = PH_IDLE;
      end else if (cfg.long_press_ticks != '0) begin
        phase_next       = PH_HOLD;
        phase_count_next = '0;
        poll_count_next  = '0;
      end else begin
        classify   = 1'b1;
        phase_next = PH_IDLE;
      end
    end

    // normal or double press
    if (classify) begin
      is_double = press_valid && cfg.double_press_ticks != '0 &&
                  CMP_W'(since_press_next) < CMP_W'(cfg.double_press_ticks);
      since_press_next = '0;
      toggle_bit_next  = ~toggle_bit;
      press_valid_next = ~is_double;
      if (is_double) begin
        double_toggle_bit_next = ~double_toggle_bit;
      end
    end

    if (long_hit) begin
      long_toggle_bit_next = ~long_toggle_bit;
    end

    res_next.press_event       = classify && !is_double;
    res_next.long_event        = long_hit;
    res_next.double_event      = is_double;
    res_next.toggle_out        = toggle_bit_next;
    res_next.long_toggle_out   = long_toggle_bit_next;
    res_next.double_toggle_out = double_toggle_bit_next;
    res_next.busy_res          = (phase_next != PH_IDLE);
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      phase_count       <= '0;
      poll_count        <= '0;
      prev_level        <= bpc_pkg::RST_IDLE_LEVEL;
      since_press       <= '0;
      press_valid       <= 1'b0;
      toggle_bit        <= bpc_pkg::RST_INIT_TOGGLE;
      long_toggle_bit   <= bpc_pkg::RST_INIT_LONG;
      double_toggle_bit <= bpc_pkg::RST_INIT_DOUBLE;
    end else if (tick) begin
      phase             <= phase_next;
      phase_count       <= phase_count_next;
      poll_count        <= poll_count_next;
      prev_level        <= pin_level;
      since_press       <= since_press_next;
      press_valid       <= press_valid_next;
      toggle_bit        <= toggle_bit_next;
      long_toggle_bit   <= long_toggle_bit_next;
      double_toggle_bit <= double_toggle_bit_next;
    end
  end

  // checks
  `BPC_ASSERT_IMP(a_press_ends_idle, clk, rst, tick && (res_next.press_event || res_next.double_event), !res_next.busy_res, "press event must return to idle")
  `BPC_ASSERT_IMP(a_long_holds, clk, rst, tick && res_next.long_event, res_next.busy_res && phase == PH_HOLD, "long event only from hold, then wait for release")
  `BPC_ASSERT_NXT(a_double_clears, clk, rst, tick && res_next.double_event, !press_valid, "double press must clear the earlier press")
  `BPC_ASSERT_IMP(a_poll_range, clk, rst, 1'b1, poll_count < POLL_LAST, "poll counter out of range")

endmodule

### rtl/core/bpc_outbuf.sv
// Two-entry result buffer: output register plus skid register
// Depends on bpc_pkg and button_press_classifier_unit_assert.svh
`timescale 1ns / 1ps
`include "button_press_classifier_unit_assert.svh"

module bpc_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bpc_pkg::bpc_result_t  push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpc_pkg::bpc_result_t  out_data
);

  logic                 skid_valid;
  bpc_pkg::bpc_result_t skid_data;

  assign can_push = ~skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (push && out_valid && !out_ready) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (push && out_valid && !out_ready) begin
      skid_data <= push_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

  // checks
  `BPC_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid entry without output entry")
  `BPC_ASSERT_NXT(a_stall_to_skid, clk, rst, push && out_valid && !out_ready && !skid_valid, skid_valid && out_valid, "stalled request lost")
  `BPC_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && out_ready, out_valid && !skid_valid, "skid entry not moved forward")

endmodule

### rtl/core/button_press_classifier_unit.sv
// Top level of the button press classifier: stream ports and configuration port
// Depends on bpc_pkg, bpc_cfg, bpc_core and bpc_outbuf
// Results: each accepted tick request is registered in the result buffer, then shown.
// Throughput: one tick per cycle while the skid entry is free; the two-entry result
// buffer keeps input open for one more request while a result stalls at the output.
// Reset (rst, synchronous): registers to their reset values, idle phase, buffer empty.
`timescale 1ns / 1ps

module button_press_classifier_unit #(
  parameter int POLL_TICKS = bpc_pkg::DEF_POLL_TICKS,
  parameter int TIME_BITS  = bpc_pkg::DEF_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [0] pin_level
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] press_event, [1] long_event, [2] double_event, [3] toggle_out,
  // [4] long_toggle_out, [5] double_toggle_out, [6] busy_res
  output logic [bpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  bpc_pkg::bpc_cfg_t    cfg;
  bpc_pkg::bpc_result_t res_next;
  bpc_pkg::bpc_result_t res_out;
  logic                 tick;
  logic                 can_push;

  assign s_axis_tready = can_push;
  assign tick          = s_axis_tvalid && can_push;
  assign m_axis_tdata  = {1'b0, res_out};

  // configuration registers
  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // classifier state
  bpc_core #(
    .POLL_TICKS (POLL_TICKS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .pin_level (s_axis_tdata[0]),
    .cfg       (cfg),
    .res_next  (res_next)
  );

  // result buffer
  bpc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (res_next),
    .can_push  (can_push),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_out)
  );

endmodule

### tb/sv/bpc_checker.sv
// Checker for the button press classifier: watches both streams and the register port
// Keeps its own copy of the classifier state and compares every result request in order
// Depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_checker
  import bpc_pkg::*;
#(
  parameter int POLL_TICKS = DEF_POLL_TICKS,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [0] pin_level
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] press_event, [1] long_event, [2] double_event, [3] toggle_out,
  // [4] long_toggle_out, [5] double_toggle_out, [6] busy_res
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     pending,
  output int                     fail_count
);

  typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_HOLD, PH_RELEASE} phase_e;

  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

  // register copies
  logic [REG_TIME_W-1:0] debounce_len, long_len, double_window;
  logic                  idle_pin;

  // classifier state
  phase_e                phase;
  logic [TIME_BITS-1:0]  phase_cnt, since_press;
  logic [4:0]            poll_cnt;
  logic                  last_pin, press_armed;
  logic                  tgl, long_tgl, dbl_tgl;

  bpc_result_t           expected_q[$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a, int unsigned b);
    longint unsigned sum;
    sum = a;
    sum = sum + b;
    return (sum > TIME_TOP) ? TIME_TOP : sum[TIME_BITS-1:0];
  endfunction

  // wraps at 5 bits like the hardware counter
  function automatic bit poll_due();
    poll_cnt = poll_cnt + 5'd1;
    if (poll_cnt >= POLL_TICKS) begin
      poll_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // a recognized press is double if an armed press lies inside the window
  function automatic void register_press(inout bpc_result_t r);
    if (press_armed && double_window != 0 && since_press < double_window) begin
      dbl_tgl        = ~dbl_tgl;
      tgl            = ~tgl;
      press_armed    = 1'b0;
      since_press    = '0;
      r.double_event = 1'b1;
    end else begin
      press_armed   = 1'b1;
      since_press   = '0;
      tgl           = ~tgl;
      r.press_event = 1'b1;
    end
  endfunction

  function automatic bpc_result_t classify_tick(logic pin);
    bpc_result_t r;
    logic        active;
    bit          due;
    r      = '0;
    active = (pin != idle_pin);
    if (press_armed) since_press = sat_add(since_press, 1);

    case (phase)
      PH_IDLE: begin
        if (last_pin == idle_pin && active) begin
          phase     = PH_DEBOUNCE;
          phase_cnt = '0;
        end
      end
      PH_DEBOUNCE: begin
        phase_cnt = sat_add(phase_cnt, 1);
      end
      PH_HOLD: begin
        due = poll_due();
        if (due) begin
          phase_cnt = sat_add(phase_cnt, POLL_TICKS);
          if (!active) begin
            register_press(r);
            phase = PH_IDLE;
          end else if (phase_cnt >= long_len) begin
            long_tgl     = ~long_tgl;
            r.long_event = 1'b1;
            phase        = PH_RELEASE;
            poll_cnt     = '0;
          end
        end
      end
      default: begin
        due = poll_due();
        if (due && !active) phase = PH_IDLE;
      end
    endcase

    // debounce sample, possibly in the edge tick itself
    if (phase == PH_DEBOUNCE && phase_cnt >= debounce_len) begin
      if (!active) begin
        phase = PH_IDLE;
      end else if (long_len != 0) begin
        phase     = PH_HOLD;
        phase_cnt = '0;
        poll_cnt  = '0;
      end else begin
        register_press(r);
        phase = PH_IDLE;
      end
    end

    last_pin            = pin;
    r.toggle_out        = tgl;
    r.long_toggle_out   = long_tgl;
    r.double_toggle_out = dbl_tgl;
    r.busy_res          = (phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %b, got %b", name, want, got);
      fail_count++;
    end
  endfunction

  // results are compared before new requests are queued at the same edge
  always @(posedge clk) begin : watch
    bpc_result_t seen, want;
    if (rst) begin
      debounce_len  = RST_DEBOUNCE;
      long_len      = RST_LONG_PRESS;
      double_window = RST_DOUBLE_PRESS;
      idle_pin      = RST_IDLE_LEVEL;
      phase         = PH_IDLE;
      phase_cnt     = '0;
      poll_cnt      = '0;
      last_pin      = RST_IDLE_LEVEL;
      since_press   = '0;
      press_armed   = 1'b0;
      tgl           = RST_INIT_TOGGLE;
      long_tgl      = RST_INIT_LONG;
      dbl_tgl       = RST_INIT_DOUBLE;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = bpc_result_t'(m_axis_tdata[$bits(bpc_result_t)-1:0]);
        if (expected_q.size() == 0) begin
          $error("result request with no tick waiting: %b", seen);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("press_event", want.press_event, seen.press_event);
          check_field("long_event", want.long_event, seen.long_event);
          check_field("double_event", want.double_event, seen.double_event);
          check_field("toggle_out", want.toggle_out, seen.toggle_out);
          check_field("long_toggle_out", want.long_toggle_out, seen.long_toggle_out);
          check_field("double_toggle_out", want.double_toggle_out, seen.double_toggle_out);
          check_field("busy_res", want.busy_res, seen.busy_res);
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(classify_tick(s_axis_tdata[0]));
      // the initial toggle registers only matter at reset, which happens once
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE:     debounce_len  = cfg_wdata;
          CFG_LONG_PRESS:   long_len      = cfg_wdata;
          CFG_DOUBLE_PRESS: double_window = cfg_wdata;
          CFG_IDLE_LEVEL:   idle_pin      = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending <= expected_q.size();
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for button_press_classifier_unit: clock, reset, tick and register stimulus
// Depends on bpc_pkg, the unit under test and bpc_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCH_LIMIT   = 1000;
  localparam int RANDOM_TICKS  = 620;
  localparam int CALM_FROM     = 470;
  localparam int WIDE_GAP      = 120;
  localparam int DEB_HOLD      = 80;
  localparam int HOLD_RUN      = 130;
  localparam logic [bpc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = bpc_pkg::CFG_INIT_DBL_TGL + 1'b1;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bpc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_we = 1'b0;
  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  int   pending, fail_count;
  int   idle_cycles = 0;
  int   ticks_sent = 0;
  int   settings = 0;
  int   send_run = 0;
  bit   calm = 1'b0;
  logic idle_pin = bpc_pkg::RST_IDLE_LEVEL;

  always #4 clk = ~clk;

  button_press_classifier_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bpc_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .pending(pending), .fail_count(fail_count)
  );

  // result side: ready stretches broken by stall bursts
  initial begin
    int run;
    forever begin
      run = $urandom_range(0, 60);
      repeat (run) @(posedge clk);
      @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no request moving on either stream
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // one tick request, with an occasional gap in front of it
  task automatic put_tick(input logic lvl);
    if (!calm && send_run == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      send_run = $urandom_range(0, 40);
    end else if (send_run > 0) begin
      send_run--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(bpc_pkg::IN_DATA_W-1){1'b0}}, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) put_tick(lvl);
  endtask

  // idle for gap ticks, then active for hold ticks
  task automatic press(input int gap, input int hold);
    hold_level(idle_pin, gap);
    hold_level(~idle_pin, hold);
  endtask

  // stop sending and wait until every tick has its result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // writes every register, junk in the unused bits, plus an index past the list
  task automatic program_regs(input int deb, input int lng, input int dbl, input logic idle);
    cfg_we    <= 1'b1;
    cfg_index <= bpc_pkg::CFG_DEBOUNCE;
    cfg_wdata <= deb[15:0];
    @(posedge clk);
    cfg_index <= bpc_pkg::CFG_LONG_PRESS;
    cfg_wdata <= lng[15:0];
    @(posedge clk);
    cfg_index <= bpc_pkg::CFG_DOUBLE_PRESS;
    cfg_wdata <= dbl[15:0];
    @(posedge clk);
    cfg_index <= bpc_pkg::CFG_IDLE_LEVEL;
    cfg_wdata <= {15'($urandom), idle};
    @(posedge clk);
    cfg_index <= bpc_pkg::CFG_INIT_TOGGLE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_index <= bpc_pkg::CFG_INIT_LONG_TGL;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_index <= bpc_pkg::CFG_INIT_DBL_TGL;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    idle_pin = idle;
    settings++;
  endtask

  initial begin
    int deb, lng, dbl, lim, n, base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: debounce of 20 ticks, plain presses only
    press(3, 24);
    hold_level(idle_pin, 3);
    settle();

    // zero debounce: press in the edge tick, then double, then plain again
    program_regs(0, 0, 30, 1'b1);
    press(1, 1);
    press(2, 2);
    press(1, 1);
    settle();

    // inverted idle level, release inside debounce, bounce while busy
    program_regs(3, 0, 0, 1'b0);
    press(1, 2);
    hold_level(idle_pin, 3);
    press(0, 1);
    hold_level(idle_pin, 1);
    hold_level(~idle_pin, 5);
    hold_level(idle_pin, 2);
    settle();

    // widest double window: a second press long after the first is still double
    program_regs(0, 0, 65535, 1'b1);
    press(2, 1);
    hold_level(idle_pin, WIDE_GAP);
    press(0, 1);
    hold_level(idle_pin, 2);
    settle();

    // longest debounce: the wait outlasts the press, so no event
    program_regs(65535, 0, 65535, 1'b0);
    press(2, DEB_HOLD);
    hold_level(idle_pin, 2);
    settle();

    // longest hold length: released before it, so a plain press at the next poll
    program_regs(0, 65535, 0, 1'b1);
    press(2, HOLD_RUN);
    hold_level(idle_pin, 30);
    settle();

    // random settings, mostly well-formed presses with some noise
    base = ticks_sent;
    n = 0;
    while (n < RANDOM_TICKS) begin
      case ($urandom_range(0, 3))
        0:       deb = 0;
        1:       deb = $urandom_range(1, 6);
        default: deb = $urandom_range(7, 30);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    lng = 0;
        2:       lng = $urandom_range(1, 25);
        3, 4:    lng = $urandom_range(26, 150);
        default: lng = 65535;
      endcase
      case ($urandom_range(0, 5))
        0:       dbl = 0;
        1, 2:    dbl = $urandom_range(1, 80);
        3, 4:    dbl = $urandom_range(81, 400);
        default: dbl = 65535;
      endcase
      if (n >= CALM_FROM) calm = 1'b1;
      program_regs(deb, lng, dbl, 1'($urandom));
      lim = deb + lng + 60;
      if (lim > 200) lim = 200;
      repeat ($urandom_range(2, 5)) begin
        n = ticks_sent - base;
        if (n >= CALM_FROM) calm = 1'b1;
        if (n >= RANDOM_TICKS) break;
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8)) put_tick(1'($urandom));
        end else if ($urandom_range(0, 1) == 0) begin
          press($urandom_range(1, 10), $urandom_range(0, lim));
        end else begin
          press($urandom_range(10, 60), $urandom_range(0, lim));
        end
      end
      // long enough at idle for every phase to end before the next write
      hold_level(idle_pin, 40);
      n = ticks_sent - base;
      settle();
    end

    repeat (4) @(posedge clk);
    $display("ran %0d tick requests over %0d register settings", ticks_sent, settings);
    $display("incl. widest double window, longest debounce and hold, bounces and noise");
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
